// File: rtl/prss_pkg.sv
// ----------------------------------------------------------------------------
// prss_pkg
// shared types, sizes and the microcode table for the pascal row square sum
// ----------------------------------------------------------------------------
package prss_pkg;

  // largest row whose square sum fits the result
  localparam int MAX_ROW     = 33;
  localparam int STORE_DEPTH = MAX_ROW + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  // widest entry of row MAX_ROW is below 2^31
  localparam int ENTRY_W     = 31;
  localparam int PROD_W      = 2 * ENTRY_W;
  localparam int SUM_W       = 63;
  localparam int ROW_W       = 6;
  localparam int UPC_W       = 4;

  typedef logic [UPC_W-1:0]   upc_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [SUM_W-1:0]   sum_t;

  // microprogram step addresses
  localparam upc_t ST_IDLE    = 4'd0;
  localparam upc_t ST_CHECK   = 4'd1;
  localparam upc_t ST_INIT    = 4'd2;
  localparam upc_t ST_ROW     = 4'd3;
  localparam upc_t ST_INNER   = 4'd4;
  localparam upc_t ST_ROW_END = 4'd5;
  localparam upc_t ST_SUM     = 4'd6;
  localparam upc_t ST_SQUARE  = 4'd7;
  localparam upc_t ST_DRAIN   = 4'd8;
  localparam upc_t ST_DONE    = 4'd9;
  localparam upc_t ST_RETURN  = 4'd10;

  typedef enum logic [1:0] {K_HOLD, K_ZERO, K_ONE, K_INC} k_op_t;
  typedef enum logic [1:0] {R_HOLD, R_ONE, R_INC} r_op_t;
  typedef enum logic [1:0] {C_HOLD, C_ONE, C_DATA} carry_op_t;
  typedef enum logic [1:0] {W_NONE, W_FIRST_ONE, W_K_SUM, W_R_ONE} wr_op_t;
  typedef enum logic [1:0] {P_HOLD, P_CLEAR, P_SQUARE} prod_op_t;

  typedef enum logic [3:0] {
    J_NEVER,
    J_ALWAYS,
    J_NOT_ACCEPT,
    J_OVF,
    J_N_ZERO,
    J_R_EQ_1,
    J_K_NEXT_LT_R,
    J_R_LT_N,
    J_K_LT_N,
    J_OUT_BUSY
  } jump_t;

  typedef struct packed {
    logic      accept;
    k_op_t     k_op;
    r_op_t     r_op;
    carry_op_t carry_op;
    wr_op_t    wr_op;
    prod_op_t  prod_op;
    logic      acc_add;
    logic      out_ld;
    jump_t     jump;
    upc_t      target;
  } ctrl_t;

  typedef struct packed {
    logic ovf;
    logic n_zero;
    logic r_eq_1;
    logic k_next_lt_r;
    logic r_lt_n;
    logic k_lt_n;
    logic out_busy;
  } status_t;

  localparam ctrl_t CTRL_NOP = '{
    accept:   1'b0,
    k_op:     K_HOLD,
    r_op:     R_HOLD,
    carry_op: C_HOLD,
    wr_op:    W_NONE,
    prod_op:  P_HOLD,
    acc_add:  1'b0,
    out_ld:   1'b0,
    jump:     J_NEVER,
    target:   ST_IDLE
  };

  // microcode rom
  function automatic ctrl_t ucode_word(input upc_t addr);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (addr)
      ST_IDLE: begin
        w.accept = 1'b1;
        w.jump   = J_NOT_ACCEPT;
        w.target = ST_IDLE;
      end
      ST_CHECK: begin
        w.jump   = J_OVF;
        w.target = ST_DONE;
      end
      ST_INIT: begin
        w.wr_op  = W_FIRST_ONE;
        w.r_op   = R_ONE;
        w.jump   = J_N_ZERO;
        w.target = ST_SUM;
      end
      ST_ROW: begin
        w.k_op     = K_ONE;
        w.carry_op = C_ONE;
        w.jump     = J_R_EQ_1;
        w.target   = ST_ROW_END;
      end
      ST_INNER: begin
        w.wr_op    = W_K_SUM;
        w.carry_op = C_DATA;
        w.k_op     = K_INC;
        w.jump     = J_K_NEXT_LT_R;
        w.target   = ST_INNER;
      end
      ST_ROW_END: begin
        w.wr_op  = W_R_ONE;
        w.r_op   = R_INC;
        w.jump   = J_R_LT_N;
        w.target = ST_ROW;
      end
      ST_SUM: begin
        w.k_op    = K_ZERO;
        w.prod_op = P_CLEAR;
      end
      ST_SQUARE: begin
        w.prod_op = P_SQUARE;
        w.acc_add = 1'b1;
        w.k_op    = K_INC;
        w.jump    = J_K_LT_N;
        w.target  = ST_SQUARE;
      end
      ST_DRAIN: begin
        w.acc_add = 1'b1;
      end
      ST_DONE: begin
        w.out_ld = 1'b1;
        w.jump   = J_OUT_BUSY;
        w.target = ST_DONE;
      end
      ST_RETURN: begin
        w.jump   = J_ALWAYS;
        w.target = ST_IDLE;
      end
      default: begin
        w.jump   = J_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/pascal_row_square_sum.sv
// ----------------------------------------------------------------------------
// pascal_row_square_sum
// sum of the squares of one row of pascal's triangle, microcoded
// ----------------------------------------------------------------------------
// latency for row n <= 33 (accept to out_valid) is set by one row store write
// per inner entry and one squaring per entry on the multiplier; rows above 33
// go from the check step straight to the done step; one transaction at a
// time, next accept in the idle step via the return step once the result is
// registered; synchronous reset returns the step counter to idle and clears
// out_valid, the row store is rebuilt from row 0 for each in-range transaction
// ----------------------------------------------------------------------------
module pascal_row_square_sum (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  row_index,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [62:0] square_sum,
  output logic        overflow
);

  // control word of the current microcode step
  prss_pkg::ctrl_t   ctrl;
  // branch conditions back from the datapath
  prss_pkg::status_t status;

  // only the idle step takes a new transaction
  assign in_stall = !ctrl.accept;

  // step counter and microcode rom
  prss_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  // row store, adder, squarer, accumulator and output register
  prss_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .in_valid   (in_valid),
    .row_index  (row_index),
    .out_stall  (out_stall),
    .status     (status),
    .out_valid  (out_valid),
    .square_sum (square_sum),
    .overflow   (overflow)
  );

endmodule

// File: rtl/prss_sequencer.sv
// ----------------------------------------------------------------------------
// prss_sequencer
// step counter, microcode lookup and conditional jumps
// ----------------------------------------------------------------------------
module prss_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  prss_pkg::status_t status,
  output prss_pkg::ctrl_t   ctrl
);

  prss_pkg::upc_t upc;
  prss_pkg::upc_t upc_next;
  logic           taken;

  assign ctrl = prss_pkg::ucode_word(upc);

  always_comb begin
    unique case (ctrl.jump)
      prss_pkg::J_NEVER:       taken = 1'b0;
      prss_pkg::J_ALWAYS:      taken = 1'b1;
      prss_pkg::J_NOT_ACCEPT:  taken = !in_valid;
      prss_pkg::J_OVF:         taken = status.ovf;
      prss_pkg::J_N_ZERO:      taken = status.n_zero;
      prss_pkg::J_R_EQ_1:      taken = status.r_eq_1;
      prss_pkg::J_K_NEXT_LT_R: taken = status.k_next_lt_r;
      prss_pkg::J_R_LT_N:      taken = status.r_lt_n;
      prss_pkg::J_K_LT_N:      taken = status.k_lt_n;
      prss_pkg::J_OUT_BUSY:    taken = status.out_busy;
      default:                 taken = 1'b1;
    endcase
    upc_next = taken ? ctrl.target : upc + prss_pkg::upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= prss_pkg::ST_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// File: rtl/prss_datapath.sv
// ----------------------------------------------------------------------------
// prss_datapath
// row store, index registers, adder, squarer, accumulator and result register
// ----------------------------------------------------------------------------
module prss_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  prss_pkg::ctrl_t            ctrl,
  input  logic                      in_valid,
  input  logic [5:0]                row_index,
  input  logic                      out_stall,
  output prss_pkg::status_t          status,
  output logic                      out_valid,
  output logic [62:0]               square_sum,
  output logic                      overflow
);

  prss_pkg::entry_t row_store [prss_pkg::STORE_DEPTH];

  prss_pkg::row_t   n;
  prss_pkg::row_t   r;
  prss_pkg::row_t   r_next;
  prss_pkg::row_t   k;
  prss_pkg::row_t   k_next;
  logic             ovf;
  prss_pkg::entry_t carry;
  prss_pkg::entry_t rdata;
  prss_pkg::prod_t  prod;
  prss_pkg::sum_t   acc;

  logic             wr_en;
  prss_pkg::addr_t  waddr;
  prss_pkg::entry_t wdata;
  logic             accept;
  logic             out_free;

  assign accept   = in_valid && ctrl.accept;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (ctrl.k_op)
      prss_pkg::K_ZERO: k_next = '0;
      prss_pkg::K_ONE:  k_next = prss_pkg::row_t'(1);
      prss_pkg::K_INC:  k_next = k + prss_pkg::row_t'(1);
      default:          k_next = k;
    endcase
    unique case (ctrl.r_op)
      prss_pkg::R_ONE: r_next = prss_pkg::row_t'(1);
      prss_pkg::R_INC: r_next = r + prss_pkg::row_t'(1);
      default:         r_next = r;
    endcase
  end

  always_comb begin
    wr_en = 1'b1;
    waddr = k[prss_pkg::ADDR_W-1:0];
    wdata = rdata + carry;
    unique case (ctrl.wr_op)
      prss_pkg::W_FIRST_ONE: begin
        waddr = '0;
        wdata = prss_pkg::entry_t'(1);
      end
      prss_pkg::W_K_SUM: begin
        waddr = k[prss_pkg::ADDR_W-1:0];
      end
      prss_pkg::W_R_ONE: begin
        waddr = r[prss_pkg::ADDR_W-1:0];
        wdata = prss_pkg::entry_t'(1);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // row store: one write, one registered read at the upcoming index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_store[waddr] <= wdata;
    end
    if (k_next < prss_pkg::row_t'(prss_pkg::STORE_DEPTH)) begin
      rdata <= row_store[k_next[prss_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    k <= k_next;
    r <= r_next;
    if (accept) begin
      n   <= row_index;
      ovf <= row_index > prss_pkg::row_t'(prss_pkg::MAX_ROW);
    end
    unique case (ctrl.carry_op)
      prss_pkg::C_ONE:  carry <= prss_pkg::entry_t'(1);
      prss_pkg::C_DATA: carry <= rdata;
      default:          carry <= carry;
    endcase
    unique case (ctrl.prod_op)
      prss_pkg::P_CLEAR:  prod <= '0;
      prss_pkg::P_SQUARE: prod <= rdata * rdata;
      default:            prod <= prod;
    endcase
    if (accept) begin
      acc <= '0;
    end else if (ctrl.acc_add) begin
      acc <= acc + prss_pkg::sum_t'(prod);
    end
    if (ctrl.out_ld && out_free) begin
      square_sum <= acc;
      overflow   <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_ld && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.ovf         = ovf;
  assign status.n_zero      = n == '0;
  assign status.r_eq_1      = r == prss_pkg::row_t'(1);
  assign status.k_next_lt_r = (k + prss_pkg::row_t'(1)) < r;
  assign status.r_lt_n      = r < n;
  assign status.k_lt_n      = k < n;
  assign status.out_busy    = !out_free;

endmodule
